FILE: hdl/sorted_key_table_with_histogram_defines.svh
// ----------------------------------------------------------------------------
// Sorted key table assertion macros
// Shared assertion shorthands for the sorted key table, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_WITH_HISTOGRAM_DEFINES_SVH
`define SORTED_KEY_TABLE_WITH_HISTOGRAM_DEFINES_SVH

// Same-cycle implication
`define SKTH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted key table check failed");

// Next-cycle implication
`define SKTH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted key table check failed");

`endif

FILE: hdl/skth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table package
// Field widths, entry and result types, status codes and the score binning
// function shared by the channel interfaces and the table.
// ----------------------------------------------------------------------------
package skth_pkg;

  localparam int KEY_W     = 27;
  localparam int SCORE_W   = 7;
  localparam int STATUS_W  = 2;
  localparam int RSP_CNT_W = 7;
  localparam int BIN_W     = 4;
  localparam int BIN_COUNT = 10;
  localparam int BIN_LAST  = 9;
  localparam int BIN_STEP  = 10;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_SCORE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PROBE,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic               has_score;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic                 found;
    status_e              status;
    logic [RSP_CNT_W-1:0] entry_count;
    logic                 bin_changed;
    logic [BIN_W-1:0]     bin_index;
    logic [RSP_CNT_W-1:0] bin_count;
  } rsp_t;

  // Whole part of a score in tenths, clamped to the last bin
  function automatic logic [BIN_W-1:0] bin_of(input logic [SCORE_W-1:0] s);
    logic [BIN_W-1:0] b;
    b = '0;
    for (int i = 1; i <= BIN_LAST; i++) begin
      if (s >= SCORE_W'(i * BIN_STEP)) begin
        b = BIN_W'(i);
      end
    end
    return b;
  endfunction

endpackage

FILE: hdl/skth_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table request channel
// Valid/ready channel carrying one insert or delete request.
// ----------------------------------------------------------------------------
interface skth_req_if
  import skth_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [KEY_W-1:0]   key;
  logic               has_score;
  logic [SCORE_W-1:0] score;

  modport source (output valid, req_type, key, has_score, score, input ready);
  modport sink   (input valid, req_type, key, has_score, score, output ready);
endinterface

FILE: hdl/skth_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface skth_rsp_if
  import skth_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [STATUS_W-1:0]  status;
  logic [RSP_CNT_W-1:0] entry_count;
  logic                 bin_changed;
  logic [BIN_W-1:0]     bin_index;
  logic [RSP_CNT_W-1:0] bin_count;

  modport source (output valid, found, status, entry_count, bin_changed, bin_index,
                  bin_count, input ready);
  modport sink   (input valid, found, status, entry_count, bin_changed, bin_index,
                  bin_count, output ready);
endinterface

FILE: hdl/sorted_key_table_with_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table with score histogram
// Keeps up to TABLE_DEPTH entries in ascending key order in one synchronous
// RAM and counts scored entries in a ten-bin histogram.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one insert or delete transaction; rsp_o returns exactly one
//   result transaction per request, in order.
//   A request is taken only while the table is idle. It runs a lower-bound
//   binary search of up to S = ceil(log2(n+1)) steps over the n held entries,
//   each step a RAM read and then a compare, then moves M entries one per
//   cycle through the RAM (M = entries above the position), then writes the
//   last one and closes the move. Accept, decide and commit steps frame the
//   search and the move. The single-port-pair RAM sets the move rate.
//   The result waits in an output register; the next request is taken while
//   it waits. If the receiver stalls and the register is still full when the
//   next request finishes, that request holds until the register drains.
//   Reset clears the fill count and the histogram; the RAM is not cleared,
//   only entries below the fill count are ever read. No clearing pass.
// ----------------------------------------------------------------------------
`include "sorted_key_table_with_histogram_defines.svh"

module sorted_key_table_with_histogram
  import skth_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skth_req_if.sink    req_i,
  skth_rsp_if.source  rsp_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // Control state
  state_e            state_q, state_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     bins_q [BIN_COUNT];
  logic [CW-1:0]     bins_d [BIN_COUNT];
  logic              rsp_valid_q, rsp_valid_d;
  logic              pend_q, pend_d;

  // Request context
  logic              ins_q, ins_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic              hs_q, hs_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     hi_q, hi_d;
  logic              found_q, found_d;
  logic              hit_hs_q, hit_hs_d;
  logic [SCORE_W-1:0] hit_score_q, hit_score_d;
  logic              apply_q, apply_d;
  status_e           status_q, status_d;
  logic              bin_chg_q, bin_chg_d;
  logic [BIN_W-1:0]  bidx_q, bidx_d;
  logic [CW-1:0]     move_q, move_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  rsp_t              rsp_q, rsp_d;

  // Table RAM
  entry_t            entry_mem [TABLE_DEPTH];
  entry_t            rdata_q;
  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_ra, mem_wa;
  entry_t            mem_wd;

  // Shared combinational terms
  logic              req_acc_c;
  logic              out_free_c;
  logic              search_end_c;
  logic [CW-1:0]     mid_c;
  logic [CW-1:0]     lo_p1_c;
  logic [CW-1:0]     fill_m1_c;
  logic              dec_apply_c;
  status_e           dec_status_c;
  logic [CW-1:0]     dec_move_c;
  logic [AW-1:0]     dec_rd_addr_c;
  logic              dec_bin_chg_c;
  logic [BIN_W-1:0]  dec_bidx_c;
  logic [CW-1:0]     bin_cur_c, bin_new_c, fill_new_c;
  logic [CW+RSP_CNT_W-1:0] fill_ext_c, bin_ext_c;

  assign req_i.ready  = (state_q == S_IDLE);
  assign req_acc_c    = req_i.valid && req_i.ready;
  assign out_free_c   = !rsp_valid_q || rsp_o.ready;
  assign search_end_c = !(lo_q < hi_q);
  assign mid_c        = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_p1_c      = lo_q + ONE_C;
  assign fill_m1_c    = fill_q - ONE_C;

  // Decide what the request does once the search has settled
  always_comb begin
    dec_apply_c   = 1'b0;
    dec_status_c  = ST_OK;
    dec_move_c    = '0;
    dec_rd_addr_c = '0;
    dec_bin_chg_c = 1'b0;
    dec_bidx_c    = '0;
    if (ins_q) begin
      if (found_q) begin
        dec_apply_c = 1'b0;
      end else if (hs_q && (score_q > SCORE_MAX)) begin
        dec_status_c = ST_BAD_SCORE;
      end else begin
        dec_apply_c   = 1'b1;
        dec_move_c    = fill_q - lo_q;
        dec_rd_addr_c = fill_m1_c[AW-1:0];
        dec_bin_chg_c = hs_q;
        dec_bidx_c    = hs_q ? bin_of(score_q) : '0;
      end
    end else if (found_q) begin
      dec_apply_c   = 1'b1;
      dec_move_c    = fill_q - lo_p1_c;
      dec_rd_addr_c = lo_p1_c[AW-1:0];
      dec_bin_chg_c = hit_hs_q;
      dec_bidx_c    = hit_hs_q ? bin_of(hit_score_q) : '0;
    end
  end

  // Commit values: fill count and touched bin
  always_comb begin
    bin_cur_c = bins_q[bidx_q];
    if (ins_q) begin
      bin_new_c = bin_cur_c + ONE_C;
    end else if (bin_cur_c != '0) begin
      bin_new_c = bin_cur_c - ONE_C;
    end else begin
      bin_new_c = bin_cur_c;
    end
    if (!apply_q) begin
      fill_new_c = fill_q;
    end else if (ins_q) begin
      fill_new_c = fill_q + ONE_C;
    end else begin
      fill_new_c = fill_m1_c;
    end
  end

  assign fill_ext_c = {{RSP_CNT_W{1'b0}}, fill_new_c};
  assign bin_ext_c  = {{RSP_CNT_W{1'b0}}, (bin_chg_q ? bin_new_c : CW'(0))};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc_c) begin
          if (!req_i.req_type && (fill_q >= DEPTH_C)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (!search_end_c) begin
          state_d = S_PROBE;
        end else if (dec_apply_c && (dec_move_c != '0)) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PROBE: state_d = S_SEARCH;
      S_SHIFT: begin
        if ((move_q == '0) && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_c) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control per state
  always_comb begin
    fill_d      = fill_q;
    bins_d      = bins_q;
    rsp_valid_d = rsp_valid_q;
    pend_d      = pend_q;
    ins_d       = ins_q;
    key_d       = key_q;
    hs_d        = hs_q;
    score_d     = score_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    found_d     = found_q;
    hit_hs_d    = hit_hs_q;
    hit_score_d = hit_score_q;
    apply_d     = apply_q;
    status_d    = status_q;
    bin_chg_d   = bin_chg_q;
    bidx_d      = bidx_q;
    move_d      = move_q;
    rd_addr_d   = rd_addr_q;
    pend_addr_d = pend_addr_q;
    rsp_d       = rsp_q;
    mem_re      = 1'b0;
    mem_ra      = '0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = rdata_q;

    // Drop the result once the receiver takes it
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_acc_c) begin
          ins_d     = !req_i.req_type;
          key_d     = req_i.key;
          hs_d      = req_i.has_score;
          score_d   = req_i.score;
          lo_d      = '0;
          hi_d      = fill_q;
          found_d   = 1'b0;
          hit_hs_d  = 1'b0;
          apply_d   = 1'b0;
          bin_chg_d = 1'b0;
          bidx_d    = '0;
          status_d  = (!req_i.req_type && (fill_q >= DEPTH_C)) ? ST_FULL : ST_OK;
        end
      end
      S_SEARCH: begin
        if (!search_end_c) begin
          mem_re = 1'b1;
          mem_ra = mid_c[AW-1:0];
        end else begin
          apply_d   = dec_apply_c;
          status_d  = dec_status_c;
          move_d    = dec_move_c;
          rd_addr_d = dec_rd_addr_c;
          bin_chg_d = dec_bin_chg_c;
          bidx_d    = dec_bidx_c;
          pend_d    = 1'b0;
        end
      end
      S_PROBE: begin
        // Narrow the bound; an equal key is the lower bound itself
        if (rdata_q.key < key_q) begin
          lo_d = mid_c + ONE_C;
        end else begin
          hi_d = mid_c;
        end
        if (rdata_q.key == key_q) begin
          found_d     = 1'b1;
          hit_hs_d    = rdata_q.has_score;
          hit_score_d = rdata_q.score;
        end
      end
      S_SHIFT: begin
        // Write back the entry read last cycle, one slot over
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = pend_addr_q;
          mem_wd = rdata_q;
        end
        // Read the next entry to move
        if (move_q != '0) begin
          mem_re      = 1'b1;
          mem_ra      = rd_addr_q;
          move_d      = move_q - ONE_C;
          pend_d      = 1'b1;
          rd_addr_d   = ins_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
          pend_addr_d = ins_q ? rd_addr_q + AW'(1) : rd_addr_q - AW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      S_DONE: begin
        if (out_free_c) begin
          // Place the new entry in the opened slot
          if (apply_q && ins_q) begin
            mem_we           = 1'b1;
            mem_wa           = lo_q[AW-1:0];
            mem_wd.key       = key_q;
            mem_wd.has_score = hs_q;
            mem_wd.score     = hs_q ? score_q : '0;
          end
          fill_d = fill_new_c;
          if (apply_q && bin_chg_q) begin
            bins_d[bidx_q] = bin_new_c;
          end
          rsp_valid_d       = 1'b1;
          rsp_d.found       = found_q;
          rsp_d.status      = status_q;
          rsp_d.entry_count = fill_ext_c[RSP_CNT_W-1:0];
          rsp_d.bin_changed = bin_chg_q;
          rsp_d.bin_index   = bidx_q;
          rsp_d.bin_count   = bin_ext_c[RSP_CNT_W-1:0];
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      for (int i = 0; i < BIN_COUNT; i++) begin
        bins_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rsp_valid_q <= rsp_valid_d;
      pend_q      <= pend_d;
      bins_q      <= bins_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ins_q       <= ins_d;
    key_q       <= key_d;
    hs_q        <= hs_d;
    score_q     <= score_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    found_q     <= found_d;
    hit_hs_q    <= hit_hs_d;
    hit_score_q <= hit_score_d;
    apply_q     <= apply_d;
    status_q    <= status_d;
    bin_chg_q   <= bin_chg_d;
    bidx_q      <= bidx_d;
    move_q      <= move_d;
    rd_addr_q   <= rd_addr_d;
    pend_addr_q <= pend_addr_d;
    rsp_q       <= rsp_d;
  end

  // Table RAM, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= entry_mem[mem_ra];
    end
  end

  // Response channel
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.found       = rsp_q.found;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.entry_count = rsp_q.entry_count;
  assign rsp_o.bin_changed = rsp_q.bin_changed;
  assign rsp_o.bin_index   = rsp_q.bin_index;
  assign rsp_o.bin_count   = rsp_q.bin_count;

  // Checks
  `SKTH_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= DEPTH_C)
  `SKTH_ASSERT_IMP(a_fill_commit, fill_q != $past(fill_q), $past(state_q == S_DONE && out_free_c))
  `SKTH_ASSERT_IMP(a_move_no_overlap, state_q == S_SHIFT && pend_q && move_q != '0, pend_addr_q != rd_addr_q)
  `SKTH_ASSERT_NEXT(a_result_load, state_q == S_DONE && out_free_c, rsp_valid_q && state_q == S_IDLE)

endmodule

FILE: test/skth_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table test package
// Request kind codes shared by the stimulus and the result checker.
// ----------------------------------------------------------------------------
package skth_tb_pkg;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_kind_e;

endpackage

FILE: test/skth_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table result checker
// Watches both channels, keeps a shadow of the sorted table and the score
// histogram, predicts one result per accepted request and compares every
// returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module skth_result_checker
  import skth_pkg::*;
  import skth_tb_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  skth_req_if  req_mon,
  skth_rsp_if  rsp_mon,
  output int   mismatches_o,
  output int   outstanding_o,
  output int   fill_o,
  output int   results_o,
  output int   full_o,
  output int   bad_score_o,
  output int   dup_o,
  output int   removed_o,
  output int   peak_fill_o
);

  // Shadow of the table contents and the histogram
  entry_t      shadow_tbl [DEPTH];
  int unsigned shadow_fill;
  int unsigned shadow_bins [BIN_COUNT];

  // Predicted results not yet returned, oldest first
  rsp_t        predicted_q [$];

  int mismatches, results, full_refusals, bad_scores, duplicates, removals, peak_fill;

  // Score in tenths to its histogram bin, top bin absorbs 90..100
  function automatic int unsigned score_bin(input logic [SCORE_W-1:0] s);
    int unsigned b;
    b = int'(s) / BIN_STEP;
    return (b > BIN_LAST) ? BIN_LAST : b;
  endfunction

  // First slot whose key is not below k
  function automatic int unsigned first_not_below(input logic [KEY_W-1:0] k);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = shadow_fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_tbl[mid].key < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one request to the shadow table and work out its result
  task automatic table_apply(input req_kind_e kind, input logic [KEY_W-1:0] k,
                             input logic hs, input logic [SCORE_W-1:0] sc,
                             output rsp_t r);
    int unsigned pos, b, j;
    logic        hit;
    r = '0;
    r.status = ST_OK;
    pos = 0;
    hit = 1'b0;
    if (!(kind == REQ_INSERT && shadow_fill >= DEPTH)) begin
      pos = first_not_below(k);
      hit = (pos < shadow_fill) && (shadow_tbl[pos].key == k);
    end
    if (kind == REQ_INSERT) begin
      if (shadow_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else if (hit) begin
        r.found = 1'b1;
      end else if (hs && sc > SCORE_MAX) begin
        r.status = ST_BAD_SCORE;
      end else begin
        // open a slot at pos and write the new entry
        for (j = shadow_fill; j > pos; j--) shadow_tbl[j] = shadow_tbl[j-1];
        shadow_tbl[pos].key = k;
        shadow_tbl[pos].has_score = hs;
        shadow_tbl[pos].score = hs ? sc : '0;
        shadow_fill++;
        if (hs) begin
          b = score_bin(sc);
          shadow_bins[b]++;
          r.bin_changed = 1'b1;
          r.bin_index = BIN_W'(b);
          r.bin_count = RSP_CNT_W'(shadow_bins[b]);
        end
      end
    end else if (hit) begin
      r.found = 1'b1;
      if (shadow_tbl[pos].has_score) begin
        b = score_bin(shadow_tbl[pos].score);
        if (shadow_bins[b] > 0) shadow_bins[b]--;
        r.bin_changed = 1'b1;
        r.bin_index = BIN_W'(b);
        r.bin_count = RSP_CNT_W'(shadow_bins[b]);
      end
      // close the gap left at pos
      for (j = pos; j + 1 < shadow_fill; j++) shadow_tbl[j] = shadow_tbl[j+1];
      shadow_fill--;
    end
    r.entry_count = RSP_CNT_W'(shadow_fill);
  endtask

  function automatic int field_bad(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      shadow_fill = 0;
      foreach (shadow_bins[i]) shadow_bins[i] = 0;
      predicted_q.delete();
      mismatches = 0;
      results = 0;
      full_refusals = 0;
      bad_scores = 0;
      duplicates = 0;
      removals = 0;
      peak_fill = 0;
    end else begin
      // compare a returned result before queuing this cycle's request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: result returned with no request outstanding", $time);
          mismatches++;
        end else begin
          want = predicted_q.pop_front();
          results++;
          mismatches += field_bad("found", 8'(want.found), 8'(rsp_mon.found));
          mismatches += field_bad("status", 8'(want.status), 8'(rsp_mon.status));
          mismatches += field_bad("entry_count", 8'(want.entry_count),
                                  8'(rsp_mon.entry_count));
          mismatches += field_bad("bin_changed", 8'(want.bin_changed),
                                  8'(rsp_mon.bin_changed));
          mismatches += field_bad("bin_index", 8'(want.bin_index), 8'(rsp_mon.bin_index));
          mismatches += field_bad("bin_count", 8'(want.bin_count), 8'(rsp_mon.bin_count));
        end
      end
      // predict the result of an accepted request
      if (req_mon.valid && req_mon.ready) begin
        table_apply(req_kind_e'(req_mon.req_type), req_mon.key, req_mon.has_score,
                    req_mon.score, want);
        predicted_q.push_back(want);
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_BAD_SCORE) bad_scores++;
        if (want.found && req_mon.req_type == REQ_INSERT) duplicates++;
        if (want.found && req_mon.req_type == REQ_DELETE) removals++;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= predicted_q.size();
    fill_o        <= shadow_fill;
    results_o     <= results;
    full_o        <= full_refusals;
    bad_score_o   <= bad_scores;
    dup_o         <= duplicates;
    removed_o     <= removals;
    peak_fill_o   <= peak_fill;
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives directed corner requests and then random fill and drain sweeps of
// inserts and deletes, with bursty request traffic and a stalling result
// receiver. The result checker beside the table predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import skth_pkg::*;
  import skth_tb_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_REQS = 550;
  localparam logic [KEY_W-1:0] KEY_TOP = '1;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_BLOCKED
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  skth_req_if req_if ();
  skth_rsp_if rsp_if ();

  int mismatches, outstanding, fill_now, results, full_cnt, bad_cnt, dup_cnt;
  int removed_cnt, peak_fill;

  // Stimulus bookkeeping: keys probably held by the table
  logic [KEY_W-1:0] live_keys [$];
  logic             filling;
  int               at_full;
  int               low_mark;

  rx_mode_e rx_mode;
  int       rx_left;
  int       rx_hold;

  sorted_key_table_with_histogram #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  skth_result_checker #(
    .DEPTH (TABLE_DEPTH)
  ) result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_if),
    .rsp_mon       (rsp_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .fill_o        (fill_now),
    .results_o     (results),
    .full_o        (full_cnt),
    .bad_score_o   (bad_cnt),
    .dup_o         (dup_cnt),
    .removed_o     (removed_cnt),
    .peak_fill_o   (peak_fill)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: switch between open, random and long-blocked stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rx_mode <= RX_OPEN;
      rx_left <= 300;
      rx_hold <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 2));
        rx_left <= $urandom_range(150, 600);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN: begin
          rsp_if.ready <= 1'b1;
        end
        RX_RANDOM: begin
          rsp_if.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (rx_hold != 0) begin
            rsp_if.ready <= 1'b0;
            rx_hold <= rx_hold - 1;
          end else begin
            rsp_if.ready <= 1'b1;
            rx_hold <= $urandom_range(20, 150);
          end
        end
      endcase
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_request(input req_kind_e kind, input logic [KEY_W-1:0] k,
                              input logic hs, input logic [SCORE_W-1:0] sc);
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.key       <= k;
    req_if.has_score <= hs;
    req_if.score     <= sc;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every predicted result to return
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Corner requests: empty table, key and score extremes, bin edges
  task automatic run_directed();
    send_request(REQ_DELETE, '0, 1'b1, 7'd127);
    send_request(REQ_INSERT, KEY_TOP, 1'b1, 7'd100);
    send_request(REQ_INSERT, '0, 1'b0, 7'd127);
    pause_sender(3);
    send_request(REQ_INSERT, '0, 1'b1, 7'd127);
    send_request(REQ_INSERT, 27'd50, 1'b1, 7'd101);
    send_request(REQ_INSERT, 27'd50, 1'b1, 7'd127);
    pause_sender(40);
    send_request(REQ_INSERT, 27'd50, 1'b1, 7'd0);
    send_request(REQ_INSERT, 27'd51, 1'b1, 7'd9);
    send_request(REQ_INSERT, 27'd52, 1'b1, 7'd10);
    send_request(REQ_INSERT, 27'd53, 1'b1, 7'd99);
    send_request(REQ_INSERT, 27'd54, 1'b1, 7'd90);
    pause_sender(1);
    send_request(REQ_INSERT, 27'd1, 1'b1, 7'd55);
    send_request(REQ_INSERT, 27'h2AAAAAA, 1'b1, 7'h55);
    send_request(REQ_INSERT, 27'h5555555, 1'b1, 7'h2A);
    send_request(REQ_DELETE, 27'd51, 1'b0, 7'd0);
    send_request(REQ_DELETE, 27'd3, 1'b1, 7'd127);
    pause_sender(90);
    send_request(REQ_DELETE, KEY_TOP, 1'b0, 7'd0);
    send_request(REQ_DELETE, '0, 1'b1, 7'd64);
    send_request(REQ_INSERT, KEY_TOP - 1'b1, 1'b0, 7'd33);
    send_request(REQ_DELETE, KEY_TOP, 1'b0, 7'd0);
  endtask

  // Pick a random request: mostly well-formed fill or drain traffic
  task automatic pick_random(output req_kind_e kind, output logic [KEY_W-1:0] k,
                             output logic hs, output logic [SCORE_W-1:0] sc);
    int unsigned roll, idx;
    roll = $urandom_range(0, 99);
    if (filling) kind = (roll < 85) ? REQ_INSERT : REQ_DELETE;
    else kind = (roll < 85) ? REQ_DELETE : REQ_INSERT;
    hs = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 6) == 0) sc = SCORE_W'($urandom_range(101, 127));
    else sc = SCORE_W'($urandom_range(0, 100));
    roll = $urandom_range(0, 99);
    if (live_keys.size() != 0 &&
        ((kind == REQ_DELETE && roll < 85) || (kind == REQ_INSERT && roll < 15))) begin
      // reuse a held key: delete hit or duplicate insert
      idx = $urandom_range(0, live_keys.size() - 1);
      k = live_keys[idx];
      if (kind == REQ_DELETE) live_keys.delete(idx);
    end else begin
      case ($urandom_range(0, 9))
        0:       k = '0;
        1:       k = KEY_TOP;
        default: k = KEY_W'($urandom());
      endcase
      if (kind == REQ_INSERT && !(hs && sc > SCORE_MAX) && fill_now < TABLE_DEPTH) begin
        live_keys.push_back(k);
        if (live_keys.size() > TABLE_DEPTH + 16) void'(live_keys.pop_front());
      end
    end
  endtask

  task automatic run_random();
    req_kind_e        kind;
    logic [KEY_W-1:0] k;
    logic             hs;
    logic [SCORE_W-1:0] sc;
    int               burst_left, gap;
    filling = 1'b1;
    at_full = 0;
    low_mark = 0;
    burst_left = $urandom_range(1, 16);
    for (int n = 0; n < RANDOM_REQS; n++) begin
      // switch to draining after a few refusals at full, refill at the low mark
      if (filling) begin
        if (fill_now >= TABLE_DEPTH) at_full++;
        if (at_full > 4) begin
          filling = 1'b0;
          at_full = 0;
          low_mark = $urandom_range(0, 12);
        end
      end else if (fill_now <= low_mark) begin
        filling = 1'b1;
      end
      if (n == RANDOM_REQS / 2) hold_until_drained();
      pick_random(kind, k, hs, sc);
      send_request(kind, k, hs, sc);
      burst_left--;
      // idle between bursts, except in one gap-free stretch
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: gap = $urandom_range(1, 3);
          4, 5, 6:    gap = $urandom_range(4, 40);
          7, 8:       gap = $urandom_range(60, 150);
          default:    gap = 0;
        endcase
        if (n < 150 || n > 230) pause_sender(gap);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= REQ_INSERT;
    req_if.key       <= '0;
    req_if.has_score <= 1'b0;
    req_if.score     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    hold_until_drained();
    run_random();
    hold_until_drained();
    repeat (100) @(posedge clk_i);
    $display("Checked %0d results: %0d full-table refusals, %0d invalid scores, %0d dup inserts",
             results, full_cnt, bad_cnt, dup_cnt);
    $display("%0d deletes removed an entry; table fill peaked at %0d of %0d",
             removed_cnt, peak_fill, TABLE_DEPTH);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Timeout with %0d results outstanding", outstanding);
    $display("Verification failed");
    $finish;
  end

endmodule
